/* rtl/core/scp_pkg.sv */
package scp_pkg;

    localparam int VALUE_BITS_DEF  = 16;
    localparam int SERVO_COUNT_DEF = 5;

    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 3;
    localparam int SETPOINT_W = 16;

    localparam logic [BYTE_W-1:0] CHR_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CHR_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CHR_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CHR_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CHR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CHR_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CHR_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CHR_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CHR_X      = 8'h78;
    localparam logic [BYTE_W-1:0] CHR_Y      = 8'h79;
    localparam logic [BYTE_W-1:0] CHR_Z      = 8'h7A;
    localparam logic [BYTE_W-1:0] CHR_V      = 8'h76;
    localparam logic [BYTE_W-1:0] CHR_W      = 8'h77;

    localparam logic [IDX_W-1:0] SERVO_X = 3'd0;
    localparam logic [IDX_W-1:0] SERVO_Y = 3'd1;
    localparam logic [IDX_W-1:0] SERVO_Z = 3'd2;
    localparam logic [IDX_W-1:0] SERVO_V = 3'd3;
    localparam logic [IDX_W-1:0] SERVO_W = 3'd4;

    // Position inside a command: letter, ignored byte, number field.
    typedef enum logic [2:0] {
        POS_LETTER = 3'b001,
        POS_SKIP   = 3'b010,
        POS_NUM    = 3'b100
    } pos_t;

    typedef enum logic [3:0] {
        PH_SKIP   = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic                  hit;
        logic [IDX_W-1:0]      idx;
    } servo_sel_t;

    typedef struct packed {
        logic                  fire;
        logic                  recognized;
        logic [IDX_W-1:0]      servo_index;
        logic [SETPOINT_W-1:0] setpoint;
    } result_t;

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == CHR_SPACE) || (c >= CHR_TAB && c <= CHR_CR);
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= CHR_ZERO) && (c <= CHR_NINE);
    endfunction

    function automatic servo_sel_t letter_to_servo(input logic [BYTE_W-1:0] c);
        servo_sel_t sel;
        sel.hit = 1'b1;
        case (c)
            CHR_X:   sel.idx = SERVO_X;
            CHR_Y:   sel.idx = SERVO_Y;
            CHR_Z:   sel.idx = SERVO_Z;
            CHR_V:   sel.idx = SERVO_V;
            CHR_W:   sel.idx = SERVO_W;
            default:
            begin
                sel.hit = 1'b0;
                sel.idx = '0;
            end
        endcase
        return sel;
    endfunction

endpackage

/* rtl/core/scp_if.sv */
interface scp_rx_if;
    logic                          valid;
    logic                          ready;
    logic [scp_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scp_result_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 recognized;
    logic [scp_pkg::IDX_W-1:0]            servo_index;
    logic signed [scp_pkg::SETPOINT_W-1:0] setpoint;

    modport source (output valid, output recognized, output servo_index, output setpoint,
                    input ready);
    modport sink   (input valid, input recognized, input servo_index, input setpoint,
                    output ready);
endinterface

/* rtl/core/scp_parser.sv */
module scp_parser #(
    parameter int VALUE_BITS  = scp_pkg::VALUE_BITS_DEF,
    parameter int SERVO_COUNT = scp_pkg::SERVO_COUNT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [scp_pkg::BYTE_W-1:0] rx_byte,
    output scp_pkg::result_t           res
);

    logic                       in_cmd_reg,  in_cmd_next;
    scp_pkg::pos_t              pos_reg,     pos_next;
    logic [scp_pkg::BYTE_W-1:0] letter_reg,  letter_next;
    scp_pkg::phase_t            phase_reg,   phase_next;
    logic                       neg_reg,     neg_next;
    logic [VALUE_BITS-1:0]      acc_reg,     acc_next;

    logic [VALUE_BITS-1:0]        acc_step;
    logic [VALUE_BITS-1:0]        acc_neg;
    logic signed [VALUE_BITS-1:0] value_s;
    scp_pkg::servo_sel_t          sel;
    logic                         digit;

    // acc * 10 + digit, wrapping at the accumulator width.
    assign acc_step = (acc_reg << 3) + (acc_reg << 1) + VALUE_BITS'(rx_byte[3:0]);
    assign acc_neg  = ~acc_reg + VALUE_BITS'(1);
    assign value_s  = neg_reg ? acc_neg : acc_reg;
    assign sel      = scp_pkg::letter_to_servo(letter_reg);
    assign digit    = scp_pkg::is_digit(rx_byte);

    always_comb
    begin
        in_cmd_next = in_cmd_reg;
        pos_next    = pos_reg;
        letter_next = letter_reg;
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        res         = '0;

        if (!in_cmd_reg)
        begin
            if (rx_byte == scp_pkg::CHR_DOLLAR)
            begin
                in_cmd_next = 1'b1;
                pos_next    = scp_pkg::POS_LETTER;
                letter_next = '0;
                phase_next  = scp_pkg::PH_SKIP;
                neg_next    = 1'b0;
                acc_next    = '0;
            end
        end
        else if (rx_byte == scp_pkg::CHR_SEMI)
        begin
            in_cmd_next = 1'b0;
            res.fire    = 1'b1;
            // An empty command never names a servo.
            if (pos_reg != scp_pkg::POS_LETTER && sel.hit &&
                {1'b0, sel.idx} < (scp_pkg::IDX_W + 1)'(SERVO_COUNT))
            begin
                res.recognized  = 1'b1;
                res.servo_index = sel.idx;
                res.setpoint    = scp_pkg::SETPOINT_W'(value_s);
            end
        end
        else
        begin
            case (pos_reg)
                scp_pkg::POS_LETTER:
                begin
                    letter_next = rx_byte;
                    pos_next    = scp_pkg::POS_SKIP;
                end
                scp_pkg::POS_SKIP:
                begin
                    pos_next = scp_pkg::POS_NUM;
                end
                scp_pkg::POS_NUM:
                begin
                    case (phase_reg)
                        scp_pkg::PH_SKIP:
                        begin
                            if (scp_pkg::is_space(rx_byte))
                            begin
                                phase_next = scp_pkg::PH_SKIP;
                            end
                            else if (rx_byte == scp_pkg::CHR_PLUS ||
                                     rx_byte == scp_pkg::CHR_MINUS)
                            begin
                                neg_next   = (rx_byte == scp_pkg::CHR_MINUS);
                                phase_next = scp_pkg::PH_SIGN;
                            end
                            else if (digit)
                            begin
                                acc_next   = acc_step;
                                phase_next = scp_pkg::PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = scp_pkg::PH_DONE;
                            end
                        end
                        scp_pkg::PH_SIGN, scp_pkg::PH_DIGITS:
                        begin
                            if (digit)
                            begin
                                acc_next   = acc_step;
                                phase_next = scp_pkg::PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = scp_pkg::PH_DONE;
                            end
                        end
                        default:
                        begin
                            phase_next = scp_pkg::PH_DONE;
                        end
                    endcase
                end
                default:
                begin
                    pos_next = scp_pkg::POS_LETTER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cmd_reg <= 1'b0;
            pos_reg    <= scp_pkg::POS_LETTER;
            letter_reg <= '0;
            phase_reg  <= scp_pkg::PH_SKIP;
            neg_reg    <= 1'b0;
            acc_reg    <= '0;
        end
        else if (step)
        begin
            in_cmd_reg <= in_cmd_next;
            pos_reg    <= pos_next;
            letter_reg <= letter_next;
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

/* rtl/core/servo_command_parser_top.sv */
// Each accepted byte is held in the input register while the parser steps on it;
// a result is registered only for the byte that closes a command.
// Throughput: one byte per cycle; the input register and the result register
// stall together only while a result waits on the output.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser
// to waiting for the start character.
module servo_command_parser_top #(
    parameter int VALUE_BITS  = scp_pkg::VALUE_BITS_DEF,
    parameter int SERVO_COUNT = scp_pkg::SERVO_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    scp_rx_if.sink        rx,
    scp_result_if.source  result
);

    logic                       s1_valid_reg, s1_valid_next;
    logic [scp_pkg::BYTE_W-1:0] s1_byte_reg;
    logic                       out_valid_reg, out_valid_next;
    scp_pkg::result_t           out_res_reg;
    scp_pkg::result_t           res;
    logic                       advance;
    logic                       step;
    logic                       rx_fire;

    assign advance  = !out_valid_reg || result.ready;
    assign rx.ready = advance || !s1_valid_reg;
    assign rx_fire  = rx.valid && rx.ready;
    assign step     = s1_valid_reg && advance;

    scp_parser #(
        .VALUE_BITS  (VALUE_BITS),
        .SERVO_COUNT (SERVO_COUNT)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (s1_byte_reg),
        .res     (res)
    );

    always_comb
    begin
        s1_valid_next  = rx.ready ? rx.valid : s1_valid_reg;
        out_valid_next = advance ? (step && res.fire) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            s1_byte_reg <= rx.rx_byte;
        end
        if (step && res.fire)
        begin
            out_res_reg <= res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.recognized  = out_res_reg.recognized;
    assign result.servo_index = out_res_reg.servo_index;
    assign result.setpoint    = out_res_reg.setpoint;

endmodule

/* rtl/core/scp_checker.sv */
module scp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              recognized,
    input logic [scp_pkg::IDX_W-1:0]         servo_index,
    input logic [scp_pkg::SETPOINT_W-1:0]    setpoint
);

    // With no result waiting, the input side must never be stalled.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    a_unrecognized_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !recognized) |-> (servo_index == '0 && setpoint == '0))
        else $error("unrecognized result carries nonzero fields");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (servo_index <= scp_pkg::SERVO_W))
        else $error("servo index out of range");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(recognized) && $stable(servo_index) && $stable(setpoint)))
        else $error("stalled result changed");

    // A result needs a byte to have entered first.
    a_result_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(!in_ready, 1))
        else $error("result appeared without an accepted item");

endmodule

bind servo_command_parser_top scp_checker u_scp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (rx.valid),
    .in_ready    (rx.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .recognized  (result.recognized),
    .servo_index (result.servo_index),
    .setpoint    (result.setpoint)
);

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [scp_pkg::BYTE_W-1:0]     byte_t;
    typedef logic [scp_pkg::SETPOINT_W-1:0] angle_t;

    typedef struct packed {
        logic                           recognized;
        logic [scp_pkg::IDX_W-1:0]      servo_index;
        angle_t                         setpoint;
    } servo_report_t;

    typedef struct {
        byte_t             data;
        int unsigned       gap;
        bit                drain;
    } rx_item_t;

    logic clk = 1'b0;
    logic rst_n;

    scp_rx_if     rx_ch();
    scp_result_if res_ch();

    servo_command_parser_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch)
    );

    always #5 clk = ~clk;

    // Parser state as the predictor tracks it.
    bit                    cmd_open;
    scp_pkg::pos_t         cmd_pos;
    byte_t                 cmd_letter;
    scp_pkg::phase_t       num_phase;
    bit                    num_neg;
    angle_t                num_acc;
    angle_t                servo_angles [scp_pkg::SERVO_COUNT_DEF];

    rx_item_t      rx_stream[$];
    servo_report_t due_reports[$];
    servo_report_t want;

    int unsigned bytes_queued;
    int unsigned bytes_accepted;
    int unsigned commands_closed;
    int unsigned servo_hits;
    int unsigned errors;
    bit          tx_burst;
    bit          out_burst;
    int unsigned out_wait;
    int unsigned hold_left;
    bit          hold_done;

    function automatic void parse_rx_byte(input byte_t c);
        servo_report_t rep;
        int            servo;
        angle_t        val;
        bit            blank;
        bit            digit;
        blank = (c == scp_pkg::CHR_SPACE) || (c >= scp_pkg::CHR_TAB && c <= scp_pkg::CHR_CR);
        digit = (c >= scp_pkg::CHR_ZERO) && (c <= scp_pkg::CHR_NINE);
        if (!cmd_open)
        begin
            if (c == scp_pkg::CHR_DOLLAR)
            begin
                cmd_open   = 1'b1;
                cmd_pos    = scp_pkg::POS_LETTER;
                cmd_letter = '0;
                num_phase  = scp_pkg::PH_SKIP;
                num_neg    = 1'b0;
                num_acc    = '0;
            end
            return;
        end
        if (c == scp_pkg::CHR_SEMI)
        begin
            cmd_open = 1'b0;
            servo = -1;
            if (cmd_pos != scp_pkg::POS_LETTER)
            begin
                case (cmd_letter)
                    scp_pkg::CHR_X: servo = int'(scp_pkg::SERVO_X);
                    scp_pkg::CHR_Y: servo = int'(scp_pkg::SERVO_Y);
                    scp_pkg::CHR_Z: servo = int'(scp_pkg::SERVO_Z);
                    scp_pkg::CHR_V: servo = int'(scp_pkg::SERVO_V);
                    scp_pkg::CHR_W: servo = int'(scp_pkg::SERVO_W);
                    default:        servo = -1;
                endcase
            end
            if (servo >= scp_pkg::SERVO_COUNT_DEF)
                servo = -1;
            val = num_neg ? -num_acc : num_acc;
            if (servo >= 0)
            begin
                servo_angles[servo] = val;
                rep.recognized  = 1'b1;
                rep.servo_index = servo[scp_pkg::IDX_W-1:0];
                rep.setpoint    = val;
                servo_hits++;
            end
            else
                rep = '0;
            due_reports.push_back(rep);
            commands_closed++;
            return;
        end
        case (cmd_pos)
            scp_pkg::POS_LETTER:
            begin
                cmd_letter = c;
                cmd_pos    = scp_pkg::POS_SKIP;
            end
            scp_pkg::POS_SKIP:
                cmd_pos = scp_pkg::POS_NUM;
            default:
            begin
                // Same order as atoi: blanks and one sign only before any digit.
                if (num_phase == scp_pkg::PH_SKIP && blank)
                    num_phase = scp_pkg::PH_SKIP;
                else if (num_phase == scp_pkg::PH_SKIP &&
                         (c == scp_pkg::CHR_PLUS || c == scp_pkg::CHR_MINUS))
                begin
                    num_neg   = (c == scp_pkg::CHR_MINUS);
                    num_phase = scp_pkg::PH_SIGN;
                end
                else if (num_phase != scp_pkg::PH_DONE && digit)
                begin
                    num_acc   = angle_t'(num_acc * 10 + angle_t'(c - scp_pkg::CHR_ZERO));
                    num_phase = scp_pkg::PH_DIGITS;
                end
                else
                    num_phase = scp_pkg::PH_DONE;
            end
        endcase
    endfunction

    task automatic queue_byte(input byte_t b, input bit drain);
        rx_item_t it;
        if ($urandom_range(0, 19) == 0)
            tx_burst = !tx_burst;
        it.data  = b;
        it.gap   = tx_burst ? 0 : $urandom_range(0, 14);
        it.drain = drain;
        rx_stream.push_back(it);
        bytes_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(byte_t'(s[i]), 1'b0);
    endtask

    task automatic queue_command(input bit drain);
        queue_byte(scp_pkg::CHR_DOLLAR, drain);
        if ($urandom_range(0, 9) < 8)
        begin
            case ($urandom_range(0, 4))
                0:       queue_byte(scp_pkg::CHR_X, 1'b0);
                1:       queue_byte(scp_pkg::CHR_Y, 1'b0);
                2:       queue_byte(scp_pkg::CHR_Z, 1'b0);
                3:       queue_byte(scp_pkg::CHR_V, 1'b0);
                default: queue_byte(scp_pkg::CHR_W, 1'b0);
            endcase
        end
        else
            queue_byte(byte_t'($urandom_range(0, 255)), 1'b0);
        queue_byte(byte_t'($urandom_range(0, 255)), 1'b0);
        repeat ($urandom_range(0, 2))
            queue_byte(($urandom_range(0, 1) == 0) ? scp_pkg::CHR_SPACE :
                       byte_t'($urandom_range(32'(scp_pkg::CHR_TAB), 32'(scp_pkg::CHR_CR))),
                       1'b0);
        case ($urandom_range(0, 3))
            0:       queue_byte(scp_pkg::CHR_PLUS, 1'b0);
            1:       queue_byte(scp_pkg::CHR_MINUS, 1'b0);
            default: ;
        endcase
        repeat ($urandom_range(0, 7))
            queue_byte(scp_pkg::CHR_ZERO + byte_t'($urandom_range(0, 9)), 1'b0);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                queue_byte(byte_t'($urandom_range(0, 255)), 1'b0);
        queue_byte(scp_pkg::CHR_SEMI, 1'b0);
    endtask

    // Sender: one item on offer at a time, held until the block takes it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= '0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                parse_rx_byte(rx_ch.rx_byte);
                bytes_accepted++;
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (rx_stream.size() == 0)
                    rx_ch.valid <= 1'b0;
                else if (rx_stream[0].gap != 0)
                begin
                    rx_stream[0].gap = rx_stream[0].gap - 1;
                    rx_ch.valid <= 1'b0;
                end
                else if (rx_stream[0].drain && due_reports.size() != 0)
                    rx_ch.valid <= 1'b0;
                else
                begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= rx_stream[0].data;
                    void'(rx_stream.pop_front());
                end
            end
        end
    end

    // Receiver: checks each report and throttles ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (due_reports.size() == 0)
                begin
                    $display("%0t: unexpected report: recognized %0b servo %0d setpoint %0d",
                             $time, res_ch.recognized, res_ch.servo_index, res_ch.setpoint);
                    errors++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (res_ch.recognized !== want.recognized)
                    begin
                        $display("%0t: recognized expected %0b actual %0b",
                                 $time, want.recognized, res_ch.recognized);
                        errors++;
                    end
                    if (res_ch.servo_index !== want.servo_index)
                    begin
                        $display("%0t: servo_index expected %0d actual %0d",
                                 $time, want.servo_index, res_ch.servo_index);
                        errors++;
                    end
                    if (res_ch.setpoint !== want.setpoint)
                    begin
                        $display("%0t: setpoint expected %0d actual %0d",
                                 $time, $signed(want.setpoint), res_ch.setpoint);
                        errors++;
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    out_burst = !out_burst;
                out_wait = out_burst ? 0 : $urandom_range(0, 14);
            end
            // One long stall of the output partway through, so the input backs up.
            if (!hold_done && bytes_accepted >= 400)
            begin
                hold_done = 1'b1;
                hold_left = 150;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (out_wait != 0)
            begin
                out_wait--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int unsigned cmd_no;
        int unsigned sel;
        rst_n = 1'b0;
        for (int i = 0; i < scp_pkg::SERVO_COUNT_DEF; i++)
            servo_angles[i] = '0;

        // Idle bytes are dropped, including a stray terminator.
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(scp_pkg::CHR_SEMI, 1'b0);
        queue_text("$;");
        queue_text("$z;");
        // Dollar as the ignored byte, a tab, a sign and a number ended by a letter.
        queue_text("$v$\t-7x;");
        queue_text("$k:5;");
        // Wraps past 16 bits to the most negative value.
        queue_text("$w 98304;");

        cmd_no = 0;
        while (bytes_queued < 950)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                repeat ($urandom_range(1, 4))
                    queue_byte(byte_t'($urandom_range(0, 255)), 1'b0);
            end
            else if (sel == 1)
            begin
                queue_byte(scp_pkg::CHR_DOLLAR, 1'b0);
                repeat ($urandom_range(0, 6))
                    queue_byte(($urandom_range(0, 3) == 0) ? scp_pkg::CHR_DOLLAR :
                               byte_t'($urandom_range(0, 255)), 1'b0);
                queue_byte(scp_pkg::CHR_SEMI, 1'b0);
            end
            else
            begin
                queue_command(cmd_no == 40 || $urandom_range(0, 49) == 0);
                cmd_no++;
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (rx_stream.size() != 0 || rx_ch.valid)
            @(posedge clk);
        while (due_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("tb: %0d bytes through the parser, %0d commands closed, %0d naming a servo",
                 bytes_accepted, commands_closed, servo_hits);
        $display("tb: final setpoints x=%0d y=%0d z=%0d v=%0d w=%0d",
                 $signed(servo_angles[0]), $signed(servo_angles[1]), $signed(servo_angles[2]),
                 $signed(servo_angles[3]), $signed(servo_angles[4]));
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
